// ===== hw/rtl/blsc_pkg.sv =====
// ----------------------------------------------------------------------------
// blsc_pkg: shared types and constants of the basic lexer token scanner
// token kinds, error codes, character codes, token and bundle records, and
// the small classification functions used by the front end
// ----------------------------------------------------------------------------
package blsc_pkg;

    // default widths of the internal position and value registers
    localparam int DEF_POSITION_BITS = 16;
    localparam int DEF_VALUE_BITS    = 32;

    // fixed widths of the token word fields
    localparam int TOKEN_LEN_W   = 8;
    localparam int TOKEN_VALUE_W = 32;
    localparam int TOKEN_POS_W   = 16;

    // bundles held between front and back end
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [4:0] {
        KIND_END    = 5'd0,
        KIND_IF     = 5'd1,
        KIND_THEN   = 5'd2,
        KIND_ELSE   = 5'd3,
        KIND_GOTO   = 5'd4,
        KIND_IDENT  = 5'd5,
        KIND_LABEL  = 5'd6,
        KIND_CONST  = 5'd7,
        KIND_PLUS   = 5'd8,
        KIND_MINUS  = 5'd9,
        KIND_STAR   = 5'd10,
        KIND_SLASH  = 5'd11,
        KIND_CARET  = 5'd12,
        KIND_EQ     = 5'd13,
        KIND_LT     = 5'd14,
        KIND_LE     = 5'd15,
        KIND_NE     = 5'd16,
        KIND_GT     = 5'd17,
        KIND_GE     = 5'd18,
        KIND_LPAREN = 5'd19,
        KIND_RPAREN = 5'd20,
        KIND_COLON  = 5'd21,
        KIND_SEMI   = 5'd22,
        KIND_ERROR  = 5'd23
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_NUM_ALPHA = 2'd1,
        ERR_UNKNOWN   = 2'd2
    } err_t;

    // character codes
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_LT         = 8'h3C;
    localparam logic [7:0] CH_EQ         = 8'h3D;
    localparam logic [7:0] CH_GT         = 8'h3E;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_CARET      = 8'h5E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    // keywords packed as their first characters
    localparam logic [31:0] KW_IF   = 32'h0000_4946;
    localparam logic [31:0] KW_THEN = 32'h5448_454E;
    localparam logic [31:0] KW_ELSE = 32'h454C_5345;
    localparam logic [31:0] KW_GOTO = 32'h474F_544F;

    typedef struct packed {
        kind_t                    kind;
        logic [TOKEN_LEN_W-1:0]   length;
        logic [TOKEN_VALUE_W-1:0] value;
        logic [TOKEN_POS_W-1:0]   line;
        logic [TOKEN_POS_W-1:0]   column;
        err_t                     err;
    } token_t;

    // tokens caused by one source byte, oldest in tok[0]
    typedef struct packed {
        logic [1:0]   count;
        token_t [2:0] tok;
    } bundle_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[CH_DIGIT_0:CH_DIGIT_9]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {CH_SPACE, [CH_TAB:CH_CR]});
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        return (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_EQ,
                          CH_LPAREN, CH_RPAREN, CH_COLON, CH_SEMI});
    endfunction

    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_CARET:  k = KIND_CARET;
            CH_EQ:     k = KIND_EQ;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_COLON:  k = KIND_COLON;
            CH_SEMI:   k = KIND_SEMI;
            default:   k = KIND_END;
        endcase
        return k;
    endfunction

    function automatic kind_t ident_kind(input logic [TOKEN_LEN_W-1:0] len,
                                         input logic [31:0] prefix);
        kind_t k;
        k = KIND_IDENT;
        if (len == TOKEN_LEN_W'(2) && prefix == KW_IF)
            k = KIND_IF;
        else if (len == TOKEN_LEN_W'(4))
        begin
            if (prefix == KW_THEN)
                k = KIND_THEN;
            else if (prefix == KW_ELSE)
                k = KIND_ELSE;
            else if (prefix == KW_GOTO)
                k = KIND_GOTO;
        end
        return k;
    endfunction

    function automatic token_t make_token(input kind_t k,
                                          input logic [TOKEN_LEN_W-1:0] len,
                                          input logic [TOKEN_VALUE_W-1:0] val,
                                          input logic [TOKEN_POS_W-1:0] ln,
                                          input logic [TOKEN_POS_W-1:0] col,
                                          input err_t e);
        token_t t;
        t.kind   = k;
        t.length = len;
        t.value  = val;
        t.line   = ln;
        t.column = col;
        t.err    = e;
        return t;
    endfunction

endpackage

// ===== hw/rtl/blsc_byte_if.sv =====
// ----------------------------------------------------------------------------
// blsc_byte_if: source byte channel
// valid/ready channel carrying one source byte and its end-of-source mark
// ----------------------------------------------------------------------------
interface blsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_source;

    modport source (output valid, char_code, end_of_source, input ready);
    modport sink (input valid, char_code, end_of_source, output ready);
endinterface

// ===== hw/rtl/blsc_token_if.sv =====
// ----------------------------------------------------------------------------
// blsc_token_if: token channel
// valid/ready channel carrying one token word
// ----------------------------------------------------------------------------
interface blsc_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [7:0]  lexeme_length;
    logic [31:0] number_value;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [1:0]  error_code;
    logic        last_of_run;

    modport source (output valid, token_kind, lexeme_length, number_value, token_line,
                    token_column, error_code, last_of_run, input ready);
    modport sink (input valid, token_kind, lexeme_length, number_value, token_line,
                  token_column, error_code, last_of_run, output ready);
endinterface

// ===== hw/rtl/blsc_front.sv =====
// ----------------------------------------------------------------------------
// blsc_front: scanner front end
// takes one source byte a cycle while the bundle queue has room, runs the
// scanner state and builds the bundle of tokens that the byte completes
// ----------------------------------------------------------------------------
module blsc_front import blsc_pkg::*;
#(
    parameter int POSITION_BITS = DEF_POSITION_BITS,
    parameter int VALUE_BITS    = DEF_VALUE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    blsc_byte_if.sink   src,
    output logic        push_valid,
    output bundle_t     push_data,
    input  logic        push_ready
);

    localparam int ACC_W = VALUE_BITS + 4;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_LESS,
        MODE_GREATER
    } mode_t;

    mode_t                    mode_reg, mode_next;
    logic [31:0]              prefix_reg, prefix_next;
    logic [VALUE_BITS-1:0]    acc_reg, acc_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] sline_reg, sline_next;
    logic [POSITION_BITS-1:0] scol_reg, scol_next;
    logic [TOKEN_LEN_W-1:0]   plen_reg, plen_next;
    logic                     goto_reg, goto_next;
    logic                     stop_reg, stop_next;

    logic [7:0]               c;
    logic                     c_alpha, c_digit;
    logic                     accept;
    logic                     do_adv, taken;
    logic [POSITION_BITS-1:0] adv_line, adv_col;
    logic [ACC_W-1:0]         acc_ext, acc_sum;
    logic [VALUE_BITS-1:0]    acc_step;
    logic [TOKEN_LEN_W-1:0]   plen_grown;
    logic [TOKEN_POS_W-1:0]   cur_line_o, cur_col_o, st_line_o, st_col_o;
    kind_t                    kind_now, kind_flush;
    token_t [3:0]             slot;
    logic [3:0]               slot_v;
    logic [1:0]               n;
    bundle_t                  bun;

    assign c       = src.char_code;
    assign c_alpha = is_alpha(c);
    assign c_digit = is_digit(c);
    assign accept  = src.valid && src.ready;

    // position after this byte, saturating
    assign adv_line = (c == CH_LF && !(&line_reg)) ? line_reg + POSITION_BITS'(1) : line_reg;
    assign adv_col  = (c == CH_LF) ? POSITION_BITS'(1)
                    : ((&col_reg) ? col_reg : col_reg + POSITION_BITS'(1));

    // times ten plus digit by shift and add, saturating
    assign acc_ext  = ACC_W'(acc_reg);
    assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(c[3:0]);
    assign acc_step = (|acc_sum[ACC_W-1:VALUE_BITS]) ? '1 : acc_sum[VALUE_BITS-1:0];

    assign plen_grown = (&plen_reg) ? plen_reg : plen_reg + TOKEN_LEN_W'(1);

    assign cur_line_o = TOKEN_POS_W'(line_reg);
    assign cur_col_o  = TOKEN_POS_W'(col_reg);
    assign st_line_o  = TOKEN_POS_W'(sline_reg);
    assign st_col_o   = TOKEN_POS_W'(scol_reg);
    assign kind_now   = ident_kind(plen_reg, prefix_reg);

    always_comb
    begin
        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        acc_next    = acc_reg;
        sline_next  = sline_reg;
        scol_next   = scol_reg;
        plen_next   = plen_reg;
        goto_next   = goto_reg;
        stop_next   = stop_reg;
        do_adv      = 1'b0;
        taken       = 1'b0;
        slot        = '0;
        slot_v      = '0;
        kind_flush  = KIND_IDENT;

        if (!stop_reg)
        begin
            // the byte against the open token
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (c_alpha || c_digit || c == CH_UNDERSCORE)
                    begin
                        if (plen_reg < TOKEN_LEN_W'(4))
                            prefix_next = {prefix_reg[23:0], c};
                        plen_next = plen_grown;
                        do_adv    = 1'b1;
                        taken     = 1'b1;
                    end
                    else
                    begin
                        slot[0]   = make_token(kind_now, plen_reg, '0, st_line_o, st_col_o,
                                               ERR_NONE);
                        slot_v[0] = 1'b1;
                        goto_next = (kind_now == KIND_GOTO);
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_NUMBER:
                begin
                    if (c_digit)
                    begin
                        acc_next  = acc_step;
                        plen_next = plen_grown;
                        do_adv    = 1'b1;
                        taken     = 1'b1;
                    end
                    else if (c_alpha || c == CH_UNDERSCORE)
                    begin
                        slot[0]   = make_token(KIND_ERROR, TOKEN_LEN_W'(1), '0, cur_line_o,
                                               cur_col_o, ERR_NUM_ALPHA);
                        slot_v[0] = 1'b1;
                        goto_next = 1'b0;
                        mode_next = MODE_IDLE;
                        stop_next = 1'b1;
                        taken     = 1'b1;
                    end
                    else
                    begin
                        slot[0]   = make_token((goto_reg || c == CH_COLON) ? KIND_LABEL
                                               : KIND_CONST, plen_reg,
                                               TOKEN_VALUE_W'(acc_reg), st_line_o, st_col_o,
                                               ERR_NONE);
                        slot_v[0] = 1'b1;
                        goto_next = 1'b0;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_LESS:
                begin
                    if (c == CH_EQ || c == CH_GT)
                    begin
                        slot[0] = make_token((c == CH_EQ) ? KIND_LE : KIND_NE,
                                             TOKEN_LEN_W'(2), '0, st_line_o, st_col_o,
                                             ERR_NONE);
                        do_adv  = 1'b1;
                        taken   = 1'b1;
                    end
                    else
                        slot[0] = make_token(KIND_LT, TOKEN_LEN_W'(1), '0, st_line_o,
                                             st_col_o, ERR_NONE);
                    slot_v[0] = 1'b1;
                    goto_next = 1'b0;
                    mode_next = MODE_IDLE;
                end
                MODE_GREATER:
                begin
                    if (c == CH_EQ)
                    begin
                        slot[0] = make_token(KIND_GE, TOKEN_LEN_W'(2), '0, st_line_o,
                                             st_col_o, ERR_NONE);
                        do_adv  = 1'b1;
                        taken   = 1'b1;
                    end
                    else
                        slot[0] = make_token(KIND_GT, TOKEN_LEN_W'(1), '0, st_line_o,
                                             st_col_o, ERR_NONE);
                    slot_v[0] = 1'b1;
                    goto_next = 1'b0;
                    mode_next = MODE_IDLE;
                end
                default:
                begin
                end
            endcase

            // the byte starts something new
            if (!taken)
            begin
                if (is_space(c))
                    do_adv = 1'b1;
                else if (c == CH_HASH)
                begin
                    slot[1]   = make_token(KIND_END, TOKEN_LEN_W'(1), '0, cur_line_o,
                                           cur_col_o, ERR_NONE);
                    slot_v[1] = 1'b1;
                    do_adv    = 1'b1;
                    stop_next = 1'b1;
                end
                else if (c_alpha || c_digit || c == CH_LT || c == CH_GT)
                begin
                    sline_next  = line_reg;
                    scol_next   = col_reg;
                    plen_next   = TOKEN_LEN_W'(1);
                    prefix_next = '0;
                    acc_next    = '0;
                    do_adv      = 1'b1;
                    if (c_alpha)
                    begin
                        mode_next   = MODE_IDENT;
                        prefix_next = {24'd0, c};
                    end
                    else if (c_digit)
                    begin
                        mode_next = MODE_NUMBER;
                        acc_next  = VALUE_BITS'(c[3:0]);
                    end
                    else if (c == CH_LT)
                        mode_next = MODE_LESS;
                    else
                        mode_next = MODE_GREATER;
                end
                else if (is_single(c))
                begin
                    slot[1]   = make_token(single_kind(c), TOKEN_LEN_W'(1), '0, cur_line_o,
                                           cur_col_o, ERR_NONE);
                    slot_v[1] = 1'b1;
                    goto_next = 1'b0;
                    do_adv    = 1'b1;
                end
                else
                begin
                    slot[1]   = make_token(KIND_ERROR, TOKEN_LEN_W'(1), '0, cur_line_o,
                                           cur_col_o, ERR_UNKNOWN);
                    slot_v[1] = 1'b1;
                    goto_next = 1'b0;
                    mode_next = MODE_IDLE;
                    stop_next = 1'b1;
                end
            end
        end

        line_next = do_adv ? adv_line : line_reg;
        col_next  = do_adv ? adv_col : col_reg;

        // final byte: close the open token and append end
        if (src.end_of_source && !stop_next)
        begin
            case (mode_next)
                MODE_IDENT:
                begin
                    kind_flush = ident_kind(plen_next, prefix_next);
                    slot[2]    = make_token(kind_flush, plen_next, '0,
                                            TOKEN_POS_W'(sline_next), TOKEN_POS_W'(scol_next),
                                            ERR_NONE);
                    slot_v[2]  = 1'b1;
                    goto_next  = (kind_flush == KIND_GOTO);
                end
                MODE_NUMBER:
                begin
                    slot[2]   = make_token(goto_next ? KIND_LABEL : KIND_CONST, plen_next,
                                           TOKEN_VALUE_W'(acc_next), TOKEN_POS_W'(sline_next),
                                           TOKEN_POS_W'(scol_next), ERR_NONE);
                    slot_v[2] = 1'b1;
                    goto_next = 1'b0;
                end
                MODE_LESS, MODE_GREATER:
                begin
                    slot[2]   = make_token((mode_next == MODE_LESS) ? KIND_LT : KIND_GT,
                                           TOKEN_LEN_W'(1), '0, TOKEN_POS_W'(sline_next),
                                           TOKEN_POS_W'(scol_next), ERR_NONE);
                    slot_v[2] = 1'b1;
                    goto_next = 1'b0;
                end
                default:
                begin
                end
            endcase
            mode_next = MODE_IDLE;
            slot[3]   = make_token(KIND_END, TOKEN_LEN_W'(1), '0, TOKEN_POS_W'(line_next),
                                   TOKEN_POS_W'(col_next), ERR_NONE);
            slot_v[3] = 1'b1;
        end

        // rearm after the final byte
        if (src.end_of_source)
        begin
            mode_next   = MODE_IDLE;
            prefix_next = '0;
            acc_next    = '0;
            line_next   = POSITION_BITS'(1);
            col_next    = POSITION_BITS'(1);
            sline_next  = POSITION_BITS'(1);
            scol_next   = POSITION_BITS'(1);
            plen_next   = '0;
            goto_next   = 1'b0;
            stop_next   = 1'b0;
        end

        // pack the used slots in order, at most three
        bun = '0;
        n   = 2'd0;
        if (slot_v[0])
        begin
            bun.tok[n] = slot[0];
            n          = n + 2'd1;
        end
        if (slot_v[1])
        begin
            bun.tok[n] = slot[1];
            n          = n + 2'd1;
        end
        if (slot_v[2])
        begin
            bun.tok[n] = slot[2];
            n          = n + 2'd1;
        end
        if (slot_v[3])
        begin
            bun.tok[n] = slot[3];
            n          = n + 2'd1;
        end
        bun.count = n;
    end

    assign src.ready  = push_ready;
    assign push_valid = src.valid && (bun.count != 2'd0);
    assign push_data  = bun;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            prefix_reg <= '0;
            acc_reg    <= '0;
            line_reg   <= POSITION_BITS'(1);
            col_reg    <= POSITION_BITS'(1);
            sline_reg  <= POSITION_BITS'(1);
            scol_reg   <= POSITION_BITS'(1);
            plen_reg   <= '0;
            goto_reg   <= 1'b0;
            stop_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            prefix_reg <= prefix_next;
            acc_reg    <= acc_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            sline_reg  <= sline_next;
            scol_reg   <= scol_next;
            plen_reg   <= plen_next;
            goto_reg   <= goto_next;
            stop_reg   <= stop_next;
        end
    end

    // dropped source never holds an open token
    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> mode_reg == MODE_IDLE)
        else $error("open token while source dropped");

    // final byte rearms the scanner
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && src.end_of_source) |=>
            (!stop_reg && mode_reg == MODE_IDLE && line_reg == POSITION_BITS'(1)))
        else $error("scanner not rearmed after final byte");

endmodule

// ===== hw/rtl/blsc_fifo.sv =====
// ----------------------------------------------------------------------------
// blsc_fifo: bundle queue
// short queue of token bundles between front and back end
// ----------------------------------------------------------------------------
module blsc_fifo import blsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    input  bundle_t push_data,
    output logic    push_ready,
    output logic    pop_valid,
    output bundle_t pop_data,
    input  logic    pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bundle_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_fire;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push_fire  = push_valid && push_ready;
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        if (push_fire && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push_fire)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("bundle queue over depth");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty bundle queue");

endmodule

// ===== hw/rtl/blsc_back.sv =====
// ----------------------------------------------------------------------------
// blsc_back: token back end
// unpacks each bundle into token words, one a cycle while tok is ready, and marks the last one
// ----------------------------------------------------------------------------
module blsc_back import blsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  bundle_t      q_data,
    output logic         q_pop,
    blsc_token_if.source tok
);

    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    bundle_t    bun_reg, bun_next;
    token_t     cur;
    logic       last_tok;
    logic       out_fire;
    logic       load;

    assign cur      = bun_reg.tok[idx_reg];
    assign last_tok = (idx_reg == bun_reg.count - 2'd1);
    assign out_fire = tok.valid && tok.ready;
    // next bundle goes in as the last word of this one leaves
    assign load     = !busy_reg || (out_fire && last_tok);
    assign q_pop    = load && q_valid;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        bun_next  = bun_reg;
        if (load)
        begin
            busy_next = q_valid;
            idx_next  = 2'd0;
            bun_next  = q_data;
        end
        else if (out_fire)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bun_reg <= bun_next;
    end

    assign tok.valid         = busy_reg;
    assign tok.token_kind    = cur.kind;
    assign tok.lexeme_length = cur.length;
    assign tok.number_value  = cur.value;
    assign tok.token_line    = cur.line;
    assign tok.token_column  = cur.column;
    assign tok.error_code    = cur.err;
    assign tok.last_of_run   = last_tok;

    a_index_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (bun_reg.count != 2'd0) && (idx_reg < bun_reg.count))
        else $error("token index outside bundle");

endmodule

// ===== hw/rtl/basic_lexer_token_scanner_top.sv =====
// ----------------------------------------------------------------------------
// basic_lexer_token_scanner_top: streaming lexical scanner
// source bytes in, tokens with kind, length, value and position out
// ----------------------------------------------------------------------------
// The scanner takes one source byte per clock on src and returns tokens on
// tok. A byte is taken whenever the bundle queue has room; the front end
// classifies it against the open token and builds, in that same cycle, the
// group of zero to three tokens it completes. Groups wait in a four-deep
// queue and the back end hands them out one token word per cycle while tok
// is ready; that back end port is what bounds the sustained rate. A token
// passes through the bundle queue and the back end's bundle register before
// it appears on tok. Each group's final word carries last_of_run. After a
// '#' or an error the rest of the source gives no tokens, and the byte
// flagged end_of_source rearms the scanner to line 1, column 1. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module basic_lexer_token_scanner_top import blsc_pkg::*;
#(
    // width of the line and column counters, saturating
    parameter int POSITION_BITS = DEF_POSITION_BITS,
    // width of the number accumulator, saturating
    parameter int VALUE_BITS    = DEF_VALUE_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    blsc_byte_if.sink    src,
    blsc_token_if.source tok
);

    // front end to queue
    logic    push_valid;
    logic    push_ready;
    bundle_t push_data;

    // queue to back end
    logic    q_valid;
    logic    q_pop;
    bundle_t q_data;

    // scanner state and token building
    blsc_front #(
        .POSITION_BITS (POSITION_BITS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src        (src),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    // decouples byte intake from token output
    blsc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_data),
        .pop        (q_pop)
    );

    // one token word a cycle while tok is ready
    blsc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .tok     (tok)
    );

endmodule

// ===== bench/tb_basic_lexer_token_scanner_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_basic_lexer_token_scanner_top: self-checking bench of the token scanner
// feeds source bytes on the byte channel and predicts every token word from
// its own scanner model, checking each word on the token channel in order
// across phases of sender idling and receiver stalling
// ----------------------------------------------------------------------------
module tb_basic_lexer_token_scanner_top;
    import blsc_pkg::*;

    // scanner states of the prediction model
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_NUMBER,
        SCAN_LESS,
        SCAN_GREATER
    } scan_mode_t;

    // one source byte as the driver presents it
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_source;
    } src_byte_t;

    // one token word as it should appear on the token channel
    typedef struct packed {
        token_t tok;
        logic   last;
    } token_word_t;

    localparam logic [15:0] POS_LIMIT   = 16'hFFFF;
    localparam logic [63:0] VALUE_LIMIT = 64'h0000_0000_FFFF_FFFF;
    localparam logic [7:0]  CH_VTAB     = 8'h0B;
    localparam logic [7:0]  CH_FFEED    = 8'h0C;

    logic clk = 1'b0;
    logic rst_n;

    blsc_byte_if  src_if ();
    blsc_token_if tok_if ();

    basic_lexer_token_scanner_top i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_if),
        .tok   (tok_if)
    );

    // bytes waiting to be driven, and token words still to arrive
    src_byte_t   pending_bytes [$];
    token_word_t expected_words [$];
    // text of the source being assembled by the stimulus
    logic [7:0]  src_text [$];

    // idling percentages of the current phase
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned mismatches     = 0;

    // byte handshake seen at the last rising edge, read by the driver
    logic src_fire = 1'b0;

    // scanner model state
    scan_mode_t  lex_mode;
    logic [31:0] word_prefix;
    logic [63:0] value_acc;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    logic [15:0] start_line;
    logic [15:0] start_col;
    logic [7:0]  word_len;
    logic        goto_seen;
    logic        src_halted;

    // tokens caused by the byte being modelled
    token_t      byte_tokens [3];
    int          byte_count;

    always #1 clk = ~clk;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]});
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return (c inside {[CH_DIGIT_0:CH_DIGIT_9]});
    endfunction

    // state after reset and after every end-of-source byte
    function automatic void clear_scanner();
        lex_mode    = SCAN_IDLE;
        word_prefix = '0;
        value_acc   = '0;
        cur_line    = 16'd1;
        cur_col     = 16'd1;
        start_line  = 16'd1;
        start_col   = 16'd1;
        word_len    = '0;
        goto_seen   = 1'b0;
        src_halted  = 1'b0;
    endfunction

    // at most three tokens per byte; any token but GOTO and End ends a goto context
    function automatic void add_token(input kind_t k, input logic [7:0] len,
                                      input logic [31:0] val, input logic [15:0] ln,
                                      input logic [15:0] col, input err_t e);
        if (byte_count < 3)
        begin
            byte_tokens[byte_count].kind   = k;
            byte_tokens[byte_count].length = len;
            byte_tokens[byte_count].value  = val;
            byte_tokens[byte_count].line   = ln;
            byte_tokens[byte_count].column = col;
            byte_tokens[byte_count].err    = e;
            byte_count++;
            if (k != KIND_GOTO && k != KIND_END)
                goto_seen = 1'b0;
        end
    endfunction

    // line and column tracking, both saturating
    function automatic void step_pos(input logic [7:0] c);
        if (c == CH_LF)
        begin
            if (cur_line != POS_LIMIT)
                cur_line++;
            cur_col = 16'd1;
        end
        else if (cur_col != POS_LIMIT)
            cur_col++;
    endfunction

    function automatic void open_token(input scan_mode_t m);
        lex_mode    = m;
        start_line  = cur_line;
        start_col   = cur_col;
        word_len    = 8'd1;
        word_prefix = '0;
        value_acc   = '0;
    endfunction

    // keywords match case-sensitively on exact length only
    function automatic void close_word();
        kind_t k;
        k = KIND_IDENT;
        if (word_len == 8'd2 && word_prefix == KW_IF)
            k = KIND_IF;
        if (word_len == 8'd4)
        begin
            if (word_prefix == KW_THEN)
                k = KIND_THEN;
            else if (word_prefix == KW_ELSE)
                k = KIND_ELSE;
            else if (word_prefix == KW_GOTO)
                k = KIND_GOTO;
        end
        add_token(k, word_len, '0, start_line, start_col, ERR_NONE);
        if (k == KIND_GOTO)
            goto_seen = 1'b1;
    endfunction

    function automatic void halt_on_error(input err_t e);
        add_token(KIND_ERROR, 8'd1, '0, cur_line, cur_col, e);
        lex_mode   = SCAN_IDLE;
        src_halted = 1'b1;
    endfunction

    // model one accepted byte and queue the token words it causes
    function automatic void predict_tokens(input logic [7:0] c, input logic eos);
        logic        taken;
        logic        hit;
        kind_t       k;
        logic [63:0] digit;
        token_word_t word;
        byte_count = 0;
        taken      = 1'b0;
        digit      = 64'(c - CH_DIGIT_0);
        if (!src_halted)
        begin
            // first let an open token take or refuse the byte
            case (lex_mode)
                SCAN_WORD:
                begin
                    if (is_letter(c) || is_numeral(c) || c == CH_UNDERSCORE)
                    begin
                        if (word_len < 8'd4)
                            word_prefix = {word_prefix[23:0], c};
                        if (word_len != 8'hFF)
                            word_len++;
                        step_pos(c);
                        taken = 1'b1;
                    end
                    else
                        close_word();
                end
                SCAN_NUMBER:
                begin
                    if (is_numeral(c))
                    begin
                        if (value_acc > (VALUE_LIMIT - digit) / 64'd10)
                            value_acc = VALUE_LIMIT;
                        else
                            value_acc = value_acc * 64'd10 + digit;
                        if (word_len != 8'hFF)
                            word_len++;
                        step_pos(c);
                        taken = 1'b1;
                    end
                    else if (is_letter(c) || c == CH_UNDERSCORE)
                    begin
                        halt_on_error(ERR_NUM_ALPHA);
                        taken = 1'b1;
                    end
                    else
                        add_token((goto_seen || c == CH_COLON) ? KIND_LABEL : KIND_CONST,
                                  word_len, value_acc[31:0], start_line, start_col, ERR_NONE);
                end
                SCAN_LESS:
                begin
                    if (c == CH_EQ || c == CH_GT)
                    begin
                        add_token((c == CH_EQ) ? KIND_LE : KIND_NE, 8'd2, '0,
                                  start_line, start_col, ERR_NONE);
                        lex_mode = SCAN_IDLE;
                        step_pos(c);
                        taken = 1'b1;
                    end
                    else
                        add_token(KIND_LT, 8'd1, '0, start_line, start_col, ERR_NONE);
                end
                SCAN_GREATER:
                begin
                    if (c == CH_EQ)
                    begin
                        add_token(KIND_GE, 8'd2, '0, start_line, start_col, ERR_NONE);
                        lex_mode = SCAN_IDLE;
                        step_pos(c);
                        taken = 1'b1;
                    end
                    else
                        add_token(KIND_GT, 8'd1, '0, start_line, start_col, ERR_NONE);
                end
                default:
                begin
                end
            endcase
            if (!taken)
                lex_mode = SCAN_IDLE;

            // a refused byte starts afresh
            if (!taken && !src_halted)
            begin
                if (c inside {CH_SPACE, [CH_TAB:CH_CR]})
                    step_pos(c);
                else if (c == CH_HASH)
                begin
                    add_token(KIND_END, 8'd1, '0, cur_line, cur_col, ERR_NONE);
                    step_pos(c);
                    src_halted = 1'b1;
                end
                else if (is_letter(c))
                begin
                    open_token(SCAN_WORD);
                    word_prefix = {24'd0, c};
                    step_pos(c);
                end
                else if (is_numeral(c))
                begin
                    open_token(SCAN_NUMBER);
                    value_acc = digit;
                    step_pos(c);
                end
                else if (c == CH_LT)
                begin
                    open_token(SCAN_LESS);
                    step_pos(c);
                end
                else if (c == CH_GT)
                begin
                    open_token(SCAN_GREATER);
                    step_pos(c);
                end
                else
                begin
                    hit = 1'b1;
                    k   = KIND_ERROR;
                    case (c)
                        CH_PLUS:   k = KIND_PLUS;
                        CH_MINUS:  k = KIND_MINUS;
                        CH_STAR:   k = KIND_STAR;
                        CH_SLASH:  k = KIND_SLASH;
                        CH_CARET:  k = KIND_CARET;
                        CH_EQ:     k = KIND_EQ;
                        CH_LPAREN: k = KIND_LPAREN;
                        CH_RPAREN: k = KIND_RPAREN;
                        CH_COLON:  k = KIND_COLON;
                        CH_SEMI:   k = KIND_SEMI;
                        default:   hit = 1'b0;
                    endcase
                    if (hit)
                    begin
                        add_token(k, 8'd1, '0, cur_line, cur_col, ERR_NONE);
                        step_pos(c);
                    end
                    else
                        halt_on_error(ERR_UNKNOWN);
                end
            end

            // last byte: close whatever is open, then append End
            if (eos && !src_halted)
            begin
                case (lex_mode)
                    SCAN_WORD:
                        close_word();
                    SCAN_NUMBER:
                        add_token(goto_seen ? KIND_LABEL : KIND_CONST, word_len,
                                  value_acc[31:0], start_line, start_col, ERR_NONE);
                    SCAN_LESS:
                        add_token(KIND_LT, 8'd1, '0, start_line, start_col, ERR_NONE);
                    SCAN_GREATER:
                        add_token(KIND_GT, 8'd1, '0, start_line, start_col, ERR_NONE);
                    default:
                    begin
                    end
                endcase
                lex_mode = SCAN_IDLE;
                add_token(KIND_END, 8'd1, '0, cur_line, cur_col, ERR_NONE);
            end
        end
        if (eos)
            clear_scanner();
        for (int i = 0; i < byte_count; i++)
        begin
            word.tok  = byte_tokens[i];
            word.last = (i == byte_count - 1);
            expected_words.insert(expected_words.size(), word);
        end
    endfunction

    // random identifier character; top 51 gives letters only, 62 adds digits and '_'
    function automatic logic [7:0] word_char(input int unsigned top);
        int unsigned idx;
        idx = $urandom_range(0, top);
        if (idx < 26)
            return 8'(CH_UPPER_A + idx);
        else if (idx < 52)
            return 8'(CH_LOWER_A + idx - 26);
        else if (idx < 62)
            return 8'(CH_DIGIT_0 + idx - 52);
        return CH_UNDERSCORE;
    endfunction

    // append one byte to the source being assembled
    function automatic void put_char(input logic [7:0] b);
        src_text.insert(src_text.size(), b);
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endtask

    task automatic push_number(input int unsigned digits);
        repeat (digits)
            put_char(8'(CH_DIGIT_0 + $urandom_range(9)));
    endtask

    // hand the assembled text to the driver, end of source on its last byte
    task automatic queue_source();
        src_byte_t b;
        for (int i = 0; i < src_text.size(); i++)
        begin
            b.char_code     = src_text[i];
            b.end_of_source = (i == src_text.size() - 1);
            pending_bytes.insert(pending_bytes.size(), b);
        end
        src_text.delete();
    endtask

    // mostly well-formed statements, now and then one broken piece
    task automatic build_random_source();
        int    pieces;
        int    break_at;
        int    pick;
        string ops;
        ops      = "+-*/^=();:<>";
        pieces   = $urandom_range(2, 8);
        break_at = ($urandom_range(3) == 0) ? $urandom_range(0, pieces - 1) : -1;
        for (int j = 0; j < pieces; j++)
        begin
            if (j == break_at)
            begin
                pick = $urandom_range(0, 2);
                case (pick)
                    0: put_char(8'($urandom_range(0, 255)));
                    1:
                    begin
                        push_number($urandom_range(1, 3));
                        put_char($urandom_range(1) ? word_char(51) : CH_UNDERSCORE);
                    end
                    default: put_char(CH_HASH);
                endcase
            end
            else
            begin
                pick = $urandom_range(0, 14);
                case (pick)
                    0:
                    begin
                        case ($urandom_range(0, 3))
                            0: push_text("IF");
                            1: push_text("THEN");
                            2: push_text("ELSE");
                            default: push_text("GOTO");
                        endcase
                    end
                    // near misses of keywords stay identifiers
                    1:
                    begin
                        case ($urandom_range(0, 3))
                            0: push_text("goto");
                            1: push_text("If");
                            2: push_text("THENX");
                            default: push_text("ELS");
                        endcase
                    end
                    2, 3:
                    begin
                        put_char(word_char(51));
                        repeat ($urandom_range(0, 5))
                            put_char(word_char(62));
                    end
                    4, 5:
                        push_number(($urandom_range(3) == 0) ? $urandom_range(9, 12)
                                                             : $urandom_range(1, 4));
                    6:
                    begin
                        push_number($urandom_range(1, 3));
                        put_char(CH_COLON);
                    end
                    7, 8, 9, 10:
                    begin
                        put_char(ops[$urandom_range(0, ops.len() - 1)]);
                        if (src_text[$] == CH_LT && $urandom_range(1))
                            put_char($urandom_range(1) ? CH_EQ : CH_GT);
                        else if (src_text[$] == CH_GT && $urandom_range(1))
                            put_char(CH_EQ);
                    end
                    11, 12:
                    begin
                        case ($urandom_range(0, 5))
                            0: put_char(CH_SPACE);
                            1: put_char(CH_TAB);
                            2: put_char(CH_LF);
                            3: put_char(CH_VTAB);
                            4: put_char(CH_FFEED);
                            default: put_char(CH_CR);
                        endcase
                    end
                    default:
                    begin
                        push_text("GOTO ");
                        push_number($urandom_range(1, 3));
                    end
                endcase
            end
            // pieces often run together, so adjacency cases come up too
            if ($urandom_range(1))
                put_char(CH_SPACE);
        end
        queue_source();
    endtask

    // reset once, all inputs known from time zero
    initial
    begin
        rst_n                = 1'b0;
        src_if.valid         = 1'b0;
        src_if.char_code     = '0;
        src_if.end_of_source = 1'b0;
        tok_if.ready         = 1'b0;
        clear_scanner();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver: a new byte only once the previous one has gone, ready rolled every cycle
    always @(negedge clk)
    begin
        src_byte_t next_byte;
        if (!rst_n)
        begin
            src_if.valid <= 1'b0;
            tok_if.ready <= 1'b0;
        end
        else
        begin
            if (!src_if.valid || src_fire)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    next_byte = pending_bytes.pop_front();
                    src_if.valid         <= 1'b1;
                    src_if.char_code     <= next_byte.char_code;
                    src_if.end_of_source <= next_byte.end_of_source;
                end
                else
                    src_if.valid <= 1'b0;
            end
            tok_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // monitor: predict on every byte taken, check every token word taken
    always @(posedge clk)
    begin
        token_word_t want;
        src_fire = rst_n && src_if.valid && src_if.ready;
        if (src_fire)
            predict_tokens(src_if.char_code, src_if.end_of_source);
        if (rst_n && tok_if.valid && tok_if.ready)
        begin
            if (expected_words.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected token word kind %0d line %0d col %0d",
                             $realtime, tok_if.token_kind, tok_if.token_line,
                             tok_if.token_column);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (tok_if.token_kind    !== want.tok.kind   ||
                    tok_if.lexeme_length !== want.tok.length ||
                    tok_if.number_value  !== want.tok.value  ||
                    tok_if.token_line    !== want.tok.line   ||
                    tok_if.token_column  !== want.tok.column ||
                    tok_if.error_code    !== want.tok.err    ||
                    tok_if.last_of_run   !== want.last)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: expected kind %0d len %0d val %0d at %0d:%0d err %0d last %0d",
                                 $realtime, want.tok.kind, want.tok.length, want.tok.value,
                                 want.tok.line, want.tok.column, want.tok.err, want.last);
                        $display("%0t: actual   kind %0d len %0d val %0d at %0d:%0d err %0d last %0d",
                                 $realtime, tok_if.token_kind, tok_if.lexeme_length,
                                 tok_if.number_value, tok_if.token_line, tok_if.token_column,
                                 tok_if.error_code, tok_if.last_of_run);
                    end
                    mismatches++;
                end
            end
        end
    end

    // stimulus: four idling phases, each drained fully before the next
    initial
    begin
        int unsigned goal;
        while (!rst_n)
            @(posedge clk);
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 71;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 71;
                end
                default:
                begin
                    src_idle_pct   = 36;
                    sink_stall_pct = 36;
                end
            endcase
            if (phase == 0)
            begin
                // keyword, two-character operators and a label closed by ':'
                push_text("IF<=1:>=");
                queue_source();
                // '<' not followed by '=' or '>', and '>' left open at the end:
                // the last byte closes an identifier, flushes '>' and adds End
                push_text("THEN<>ELSE<a>");
                queue_source();
                // number running into a letter
                push_text("9z");
                queue_source();
                // whitespace and line advance between single-character operators
                put_char(CH_TAB);
                put_char(CH_VTAB);
                put_char(CH_FFEED);
                push_text("+-*/^\n();");
                put_char(CH_CR);
                queue_source();
                // byte above the ASCII range, then a dropped zero byte
                put_char(8'hFF);
                put_char(8'h00);
                queue_source();
                // text after the end marker is dropped
                push_text("#x");
                queue_source();
                // constant saturating, still open at the end
                push_text("99999999999");
                queue_source();
                // label still open at the end after GOTO
                push_text("GOTO 7");
                queue_source();
            end
            goal = pending_bytes.size() + 8;
            while (pending_bytes.size() < goal)
                build_random_source();
            // sender holds off until every predicted word is back
            while (pending_bytes.size() != 0 || src_if.valid)
                @(posedge clk);
            while (expected_words.size() != 0)
                @(posedge clk);
        end
        // let any stray word surface before the verdict
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog far beyond the slowest correct run
    initial
    begin
        #200000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
